// ----- sv/nps_pkg.sv -----
`default_nettype none
package nps_pkg;

	localparam int DIGIT_W     = 4;
	localparam int PACK_W      = 40;
	localparam int LEN_W       = 4;
	localparam int STATUS_W    = 2;
	localparam int DIGIT_LIMIT = 10;

	localparam logic [LEN_W-1:0] LEN_RESET = 4'd10;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_INPUT  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_LAST_PERM  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_LOADED = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic cfg_wr;
	} dp_cmd_t;

endpackage
`default_nettype wire

// ----- sv/nps_ctrl.sv -----
`default_nettype none
module nps_ctrl
	import nps_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    cfg_valid,
	output logic         busy,
	output logic         cfg_ready,
	output dp_cmd_t      cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		busy        = 1'b0;
		cfg_ready   = 1'b1;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.cfg_wr  = cfg_valid;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_RUN;
				end
			end
			ST_RUN: begin
				busy      = 1'b1;
				cmd.exec  = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_run_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("run state held longer than one cycle");
	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("accepted item not executed next cycle");
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.exec))
		else $error("capture and exec in the same cycle");
`endif

endmodule
`default_nettype wire

// ----- sv/nps_dpath.sv -----
`default_nettype none
module nps_dpath
	import nps_pkg::*;
#(
	parameter int MAX_DIGITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	input  wire logic                func,
	input  wire logic [PACK_W-1:0]   start_digits,
	input  wire logic [LEN_W-1:0]    cfg_data,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [PACK_W-1:0]        perm_digits
);

	localparam int IW = $clog2(MAX_DIGITS);
	localparam int LW = $clog2(MAX_DIGITS + 1);

	logic                   func_q;
	logic [PACK_W-1:0]      in_digits_q;
	logic [LEN_W-1:0]       perm_length_q;
	logic                   loaded_q;
	logic [DIGIT_W-1:0]     store_q [MAX_DIGITS];
	logic                   done_q;
	logic [STATUS_W-1:0]    status_q;
	logic [PACK_W-1:0]      perm_digits_q;

	logic [LW-1:0]          len;
	logic [DIGIT_W-1:0]     cand [MAX_DIGITS];
	logic [DIGIT_W-1:0]     nxt [MAX_DIGITS];
	logic                   bad;
	logic                   found;
	logic [IW-1:0]          asc_i;
	logic [IW-1:0]          swap_j;
	logic [DIGIT_W-1:0]     d_i;
	logic [DIGIT_W-1:0]     d_j;
	logic [LW:0]            src_sum [MAX_DIGITS];
	logic [IW-1:0]          src [MAX_DIGITS];
	logic [STATUS_W-1:0]    res_status;
	logic [PACK_W-1:0]      res_digits;

	always_comb begin
		if (perm_length_q == '0) begin
			len = LW'(1);
		end else if (perm_length_q > LEN_W'(MAX_DIGITS)) begin
			len = LW'(MAX_DIGITS);
		end else begin
			len = perm_length_q[LW-1:0];
		end
	end

	always_comb begin
		bad = 1'b0;
		for (int p = 0; p < MAX_DIGITS; p++) begin
			cand[p] = in_digits_q[DIGIT_W*p +: DIGIT_W];
		end
		for (int p = 0; p < MAX_DIGITS; p++) begin
			if (p < int'(len) && cand[p] >= DIGIT_W'(DIGIT_LIMIT)) begin
				bad = 1'b1;
			end
			for (int q = p + 1; q < MAX_DIGITS; q++) begin
				if (q < int'(len) && cand[p] == cand[q]) begin
					bad = 1'b1;
				end
			end
		end
	end

	always_comb begin
		found = 1'b0;
		asc_i = '0;
		for (int k = 1; k < MAX_DIGITS; k++) begin
			if (k < int'(len) && store_q[k-1] < store_q[k]) begin
				found = 1'b1;
				asc_i = IW'(k - 1);
			end
		end
	end

	assign d_i = store_q[asc_i];

	always_comb begin
		swap_j = asc_i;
		for (int q = 1; q < MAX_DIGITS; q++) begin
			if (q > int'(asc_i) && q < int'(len) && store_q[q] > d_i) begin
				swap_j = IW'(q);
			end
		end
	end

	assign d_j = store_q[swap_j];

	always_comb begin
		for (int p = 0; p < MAX_DIGITS; p++) begin
			src_sum[p] = {1'b0, len} + (LW+1)'(asc_i) - (LW+1)'(p);
			src[p]     = src_sum[p][IW-1:0];
			if (p < int'(asc_i)) begin
				nxt[p] = store_q[p];
			end else if (p == int'(asc_i)) begin
				nxt[p] = d_j;
			end else if (src[p] == swap_j) begin
				nxt[p] = d_i;
			end else begin
				nxt[p] = store_q[src[p]];
			end
		end
	end

	always_comb begin
		res_status = STAT_OK;
		res_digits = '0;
		if (func_q == FUNC_LOAD) begin
			if (bad) begin
				res_status = STAT_BAD_INPUT;
			end else begin
				for (int p = 0; p < MAX_DIGITS; p++) begin
					if (p < int'(len)) begin
						res_digits[DIGIT_W*p +: DIGIT_W] = cand[p];
					end
				end
			end
		end else if (!loaded_q) begin
			res_status = STAT_NOT_LOADED;
		end else begin
			if (!found) begin
				res_status = STAT_LAST_PERM;
			end
			for (int p = 0; p < MAX_DIGITS; p++) begin
				if (p < int'(len)) begin
					res_digits[DIGIT_W*p +: DIGIT_W] = found ? nxt[p] : store_q[p];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q      <= func;
			in_digits_q <= start_digits;
		end
		if (cmd.exec) begin
			status_q      <= res_status;
			perm_digits_q <= res_digits;
			for (int p = 0; p < MAX_DIGITS; p++) begin
				if (p < int'(len)) begin
					if (func_q == FUNC_LOAD && !bad) begin
						store_q[p] <= cand[p];
					end else if (func_q == FUNC_ADVANCE && loaded_q && found) begin
						store_q[p] <= nxt[p];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= LEN_RESET;
			loaded_q      <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.cfg_wr) begin
				perm_length_q <= cfg_data;
			end
			if (cmd.exec && func_q == FUNC_LOAD && !bad) begin
				loaded_q <= 1'b1;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign perm_digits = perm_digits_q;

`ifndef ASSERT_OFF
	a_ok_needs_load: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_OK) |-> loaded_q)
		else $error("ok result without a stored permutation");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_BAD_INPUT || status == STAT_NOT_LOADED))
			|-> perm_digits == '0)
		else $error("rejected item shows nonzero digits");
`endif

endmodule
`default_nettype wire

// ----- sv/next_permutation_stepper.sv -----
`default_nettype none
// Steps a stored permutation of distinct decimal digits. Assert start with func and
// start_digits while busy is low: func load checks and stores the packed start
// permutation, func advance replaces it with its lexicographic successor if there is
// one. busy is high for the one cycle in which the datapath checks a load, or for an
// advance scans for the rightmost ascent, swaps and reverses the suffix, and commits
// the store; done pulses for exactly one cycle after that with status and perm_digits.
// A new item can be taken in the cycle done is high. done cannot be held off: capture
// the result in the cycle it is shown. perm_length is written over the cfg channel
// (cfg_ready is always high); the user must write it only while idle, as the block does not enforce it.
module next_permutation_stepper
	import nps_pkg::*;
#(
	parameter int MAX_DIGITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                func,
	input  wire logic [PACK_W-1:0]   start_digits,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [LEN_W-1:0]    cfg_data,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [PACK_W-1:0]        perm_digits
);

	dp_cmd_t cmd;

	nps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_valid (cfg_valid),
		.busy      (busy),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	nps_dpath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.start_digits (start_digits),
		.cfg_data     (cfg_data),
		.done         (done),
		.status       (status),
		.perm_digits  (perm_digits)
	);

endmodule
`default_nettype wire
